FILE: src/iirl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirl_pkg: shared types and codes for the indexed insert/remove list
// Command and status codes, field widths and the per-beat cell command.
// ----------------------------------------------------------------------------
package iirl_pkg;

  localparam int OP_W    = 3;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int LOUT_W  = 5;

  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_RESIZE = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // broadcast to every cell in the row
  typedef struct packed {
    logic                    write_en;
    logic                    shift_up;
    logic                    shift_down;
    logic                    zero_fill;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

FILE: src/iirl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirl_cell: one entry of the list
// Holds one word; loads the command value, its left or right neighbour,
// or zero, depending on its own index against position and length.
// ----------------------------------------------------------------------------
module iirl_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                             clk,
  input  iirl_pkg::cmd_t                   cmd,
  input  logic [CW-1:0]                    len,
  input  logic signed [iirl_pkg::VAL_W-1:0] left_in,
  input  logic signed [iirl_pkg::VAL_W-1:0] right_in,
  output logic signed [iirl_pkg::VAL_W-1:0] entry
);
  import iirl_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [CW-1:0]           pos_ext;
  logic signed [VAL_W-1:0] entry_next;

  assign pos_ext = CW'(cmd.pos);

  always_comb begin
    entry_next = entry;
    if (cmd.write_en && MY_IDX == pos_ext) begin
      entry_next = cmd.value;
    end else if (cmd.shift_up) begin
      if (MY_IDX == pos_ext) begin
        entry_next = cmd.value;
      end else if (MY_IDX > pos_ext) begin
        entry_next = left_in;
      end
    end else if (cmd.shift_down) begin
      if (MY_IDX >= pos_ext) begin
        entry_next = right_in;
      end
    end else if (cmd.zero_fill) begin
      if (MY_IDX >= len) begin
        entry_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

FILE: src/iirl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirl_ctrl: command decode, length register and result register
// Range and capacity checks, cell command broadcast, registered result beat.
// ----------------------------------------------------------------------------
module iirl_ctrl #(
  parameter int DEPTH = 16,
  parameter int LW    = 5,
  parameter int CW    = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [iirl_pkg::OP_W-1:0]         opcode,
  input  logic [iirl_pkg::POS_W-1:0]        position,
  input  logic signed [iirl_pkg::VAL_W-1:0] entry_value,
  input  logic [iirl_pkg::POS_W-1:0]        new_length,
  input  logic signed [iirl_pkg::VAL_W-1:0] rd_word,
  output iirl_pkg::cmd_t                    cmd,
  output logic [CW-1:0]                     len_ext,
  output logic                              busy,
  output logic                              done,
  output logic signed [iirl_pkg::VAL_W-1:0] read_value,
  output logic [iirl_pkg::LOUT_W-1:0]       current_length,
  output logic [iirl_pkg::ST_W-1:0]         status
);
  import iirl_pkg::*;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [LW-1:0]   len;
  logic [LW-1:0]   len_next;
  logic [ST_W-1:0] st_next;
  logic            acc;
  logic            rd_ok;
  logic [CW-1:0]   pos_ext;
  logic [CW-1:0]   nlen_ext;
  logic            in_list;

  assign acc      = start & ~busy;
  assign len_ext  = CW'(len);
  assign pos_ext  = CW'(position);
  assign nlen_ext = CW'(new_length);
  assign in_list  = pos_ext < len_ext;

  always_comb begin
    cmd            = '0;
    cmd.pos        = position;
    cmd.value      = entry_value;
    len_next       = len;
    st_next        = ST_OK;
    rd_ok          = 1'b0;
    case (opcode)
      OP_READ: begin
        if (in_list) rd_ok = 1'b1;
        else st_next = ST_RANGE;
      end
      OP_WRITE: begin
        if (in_list) cmd.write_en = acc;
        else st_next = ST_RANGE;
      end
      OP_INSERT: begin
        if (pos_ext > len_ext) begin
          st_next = ST_RANGE;
        end else if (len_ext >= DEPTH_C) begin
          st_next = ST_FULL;
        end else begin
          cmd.shift_up = acc;
          len_next     = LW'(len + 1'b1);
        end
      end
      OP_REMOVE: begin
        if (in_list) begin
          cmd.shift_down = acc;
          len_next       = LW'(len - 1'b1);
        end else begin
          st_next = ST_RANGE;
        end
      end
      OP_RESIZE: begin
        if (nlen_ext > DEPTH_C) begin
          st_next = ST_FULL;
        end else begin
          cmd.zero_fill = acc;
          len_next      = LW'(nlen_ext);
        end
      end
      OP_CLEAR: begin
        len_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      done <= acc;
      if (acc) begin
        len <= len_next;
      end
    end
    if (acc) begin
      read_value     <= rd_ok ? rd_word : '0;
      current_length <= LOUT_W'(len_next);
      status         <= st_next;
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(DEPTH)) else $error("list length beyond capacity");

  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    (acc && st_next != ST_OK) |=> len == $past(len))
    else $error("failed command changed the length");

  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    (acc && opcode == OP_INSERT && st_next == ST_OK) |=> len == LW'($past(len) + 1'b1))
    else $error("insert did not grow the list by one");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc)) else $error("result beat without a command");

  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> read_value == '0)
    else $error("failed command returned data");
`endif

endmodule

FILE: src/indexed_insert_remove_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_remove_list: ordered list of signed words with shift cells
// Read, write, insert-before, remove, resize and clear on a list of up to
// DEPTH entries; every command gives one result beat.
//
// Usage:
//   A command is taken at a rising edge with start high and busy low.
//   Fields: opcode, position, entry_value, new_length.
//   In the cycle after a command is taken done is high for exactly one cycle with read_value,
//   current_length and status. The receiver cannot stall; the beat is
//   taken at the edge that ends that cycle.
//   Throughput: one command per cycle while busy is low. Each entry sits in its own cell and
//   all cells load from a neighbour in the same cycle, so insert and remove
//   move the whole tail together.
//   Reset: while rst is high busy is high and the length is cleared to
//   zero; busy drops on the first edge after rst is released. Entries need
//   no reset: slots past the length are never read and are zeroed when a
//   resize exposes them.
//   Status: 0 ok, 1 index out of range, 2 capacity exceeded; a failed
//   command leaves the list unchanged.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [iirl_pkg::OP_W-1:0]         opcode,
  input  logic [iirl_pkg::POS_W-1:0]        position,
  input  logic signed [iirl_pkg::VAL_W-1:0] entry_value,
  input  logic [iirl_pkg::POS_W-1:0]        new_length,
  output logic                              done,
  output logic signed [iirl_pkg::VAL_W-1:0] read_value,
  output logic [iirl_pkg::LOUT_W-1:0]       current_length,
  output logic [iirl_pkg::ST_W-1:0]         status
);
  import iirl_pkg::*;

  localparam int LW   = $clog2(DEPTH + 1);
  localparam int CW   = (LW > POS_W) ? LW : POS_W;
  localparam int RD_N = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

  cmd_t                    cmd;
  logic [CW-1:0]           len_ext;
  logic signed [VAL_W-1:0] word [DEPTH];
  logic signed [VAL_W-1:0] rd_word;

  // only the first 2**POS_W cells are addressable by position
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (POS_W'(i) == position) rd_word = word[i];
    end
  end

  iirl_ctrl #(
    .DEPTH (DEPTH),
    .LW    (LW),
    .CW    (CW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .opcode         (opcode),
    .position       (position),
    .entry_value    (entry_value),
    .new_length     (new_length),
    .rd_word        (rd_word),
    .cmd            (cmd),
    .len_ext        (len_ext),
    .busy           (busy),
    .done           (done),
    .read_value     (read_value),
    .current_length (current_length),
    .status         (status)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_in;
    logic signed [VAL_W-1:0] right_in;

    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = word[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = word[g+1];
    end

    iirl_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .len      (len_ext),
      .left_in  (left_in),
      .right_in (right_in),
      .entry    (word[g])
    );
  end

endmodule
